/* hdl/bef_pkg.sv */
// Shared types, constants and helper functions for the bibliography entry/field tagger.
package bef_pkg;

    // Brace depth counter width; the counter saturates at all ones
    localparam int unsigned DEPTH_BITS = 8;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

    // Character codes the parser reacts to
    localparam logic [15:0] CH_AT     = 16'h0040;
    localparam logic [15:0] CH_LBRACE = 16'h007B;
    localparam logic [15:0] CH_RBRACE = 16'h007D;
    localparam logic [15:0] CH_COMMA  = 16'h002C;
    localparam logic [15:0] CH_EQUAL  = 16'h003D;
    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_TAB    = 16'h0009;
    localparam logic [15:0] CH_CR     = 16'h000D;

    // Field name lengths
    localparam logic [2:0] TITLE_LEN  = 3'd5;
    localparam logic [2:0] AUTHOR_LEN = 3'd6;
    localparam logic [2:0] INDEX_MAX  = 3'd7;

    // Result tag codes
    typedef enum logic [2:0] {
        TAG_NONE        = 3'd0,
        TAG_KEY_CHAR    = 3'd1,
        TAG_KEY_END     = 3'd2,
        TAG_TITLE_CHAR  = 3'd3,
        TAG_TITLE_END   = 3'd4,
        TAG_AUTHOR_CHAR = 3'd5,
        TAG_AUTHOR_END  = 3'd6,
        TAG_ENTRY_END   = 3'd7
    } tag_t;

    // Kind of field whose value is being read
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_TITLE  = 2'd1,
        KIND_AUTHOR = 2'd2
    } kind_t;

    // Field name matcher phase
    typedef enum logic [1:0] {
        NM_LEAD  = 2'd0,
        NM_IN    = 2'd1,
        NM_TRAIL = 2'd2,
        NM_FAIL  = 2'd3
    } nm_phase_t;

    // Candidate bits: bit 0 title still possible, bit 1 author still possible
    localparam int unsigned CAND_TITLE_BIT  = 0;
    localparam int unsigned CAND_AUTHOR_BIT = 1;
    localparam logic [1:0]  CAND_BOTH       = 2'b11;

    typedef struct packed {
        nm_phase_t  phase;
        logic [2:0] index;
        logic [1:0] cand;
    } match_t;

    localparam match_t MATCH_CLEAR = '{phase: NM_LEAD, index: 3'd0, cand: CAND_BOTH};

    // Channel payloads
    typedef struct packed {
        logic [15:0] char_code;
        logic        start_of_text;
    } bef_in_t;

    typedef struct packed {
        logic [15:0] char_out;
        tag_t        tag;
        logic        depth_saturated;
    } bef_out_t;

    // ASCII whitespace: tab through carriage return, and space
    function automatic logic is_blank(input logic [15:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Letters of "title" by position
    function automatic logic [15:0] title_char(input logic [2:0] idx);
        logic [15:0] r;
        case (idx)
            3'd0:    r = 16'h0074; // t
            3'd1:    r = 16'h0069; // i
            3'd2:    r = 16'h0074; // t
            3'd3:    r = 16'h006C; // l
            3'd4:    r = 16'h0065; // e
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    // Letters of "author" by position
    function automatic logic [15:0] author_char(input logic [2:0] idx);
        logic [15:0] r;
        case (idx)
            3'd0:    r = 16'h0061; // a
            3'd1:    r = 16'h0075; // u
            3'd2:    r = 16'h0074; // t
            3'd3:    r = 16'h0068; // h
            3'd4:    r = 16'h006F; // o
            3'd5:    r = 16'h0072; // r
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage

/* hdl/bef_name_match.sv */
// Field name matcher: next matcher state for one name character and the current match result.
module bef_name_match (
    input  bef_pkg::match_t  cur,
    input  logic [15:0]      char_code,
    output bef_pkg::match_t  nxt,
    output bef_pkg::kind_t   kind
);
    import bef_pkg::*;

    logic       blank;
    logic       compare;
    logic       title_ok;
    logic       author_ok;
    logic [1:0] cand_next;

    assign blank = is_blank(char_code);

    // Per-letter compare against both names
    assign title_ok  = (cur.index < TITLE_LEN)  && (title_char(cur.index)  == char_code);
    assign author_ok = (cur.index < AUTHOR_LEN) && (author_char(cur.index) == char_code);
    assign cand_next = {cur.cand[CAND_AUTHOR_BIT] & author_ok,
                        cur.cand[CAND_TITLE_BIT] & title_ok};

    // Leading blanks skipped, trailing blanks allowed, anything after them fails
    always_comb begin
        nxt     = cur;
        compare = 1'b0;
        case (cur.phase)
            NM_LEAD: begin
                if (!blank) begin
                    compare = 1'b1;
                end
            end
            NM_IN: begin
                if (blank) begin
                    nxt.phase = NM_TRAIL;
                end else begin
                    compare = 1'b1;
                end
            end
            default: begin
                if (!blank) begin
                    nxt.phase = NM_FAIL;
                end
            end
        endcase
        if (compare) begin
            nxt.cand  = cand_next;
            nxt.index = (cur.index == INDEX_MAX) ? cur.index : cur.index + 3'd1;
            nxt.phase = (cand_next == 2'b00) ? NM_FAIL : NM_IN;
        end
    end

    // Result when '=' arrives
    always_comb begin
        kind = KIND_NONE;
        if (cur.phase == NM_IN || cur.phase == NM_TRAIL) begin
            if (cur.cand[CAND_TITLE_BIT] && cur.index == TITLE_LEN) begin
                kind = KIND_TITLE;
            end else if (cur.cand[CAND_AUTHOR_BIT] && cur.index == AUTHOR_LEN) begin
                kind = KIND_AUTHOR;
            end
        end
    end

endmodule

/* hdl/bef_parser.sv */
// Entry parser: phase, brace depth and field state, updated once per handled character.
module bef_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  bef_pkg::bef_in_t  in_data,
    output bef_pkg::bef_out_t result
);
    import bef_pkg::*;

    typedef enum logic [2:0] {
        PH_OUTSIDE = 3'd0,
        PH_TYPE    = 3'd1,
        PH_KEY     = 3'd2,
        PH_NAME    = 3'd3,
        PH_VALUE   = 3'd4,
        PH_WAIT    = 3'd5
    } phase_t;

    phase_t                phase_reg,  phase_next;
    logic [DEPTH_BITS-1:0] depth_reg,  depth_next;
    logic                  wait_comma_reg, wait_comma_next;
    match_t                match_reg,  match_next;
    kind_t                 kind_reg,   kind_next;

    // Start-of-text view of the state
    phase_t                phase_cur;
    logic [DEPTH_BITS-1:0] depth_cur;
    logic                  wait_comma_cur;
    match_t                match_cur;
    kind_t                 kind_cur;

    match_t      match_fed;
    kind_t       match_kind;
    tag_t        tag;
    tag_t        char_tag;
    tag_t        end_tag;
    logic [15:0] c;

    assign c = in_data.char_code;

    always_comb begin
        if (in_data.start_of_text) begin
            phase_cur      = PH_OUTSIDE;
            depth_cur      = '0;
            wait_comma_cur = 1'b0;
            match_cur      = MATCH_CLEAR;
            kind_cur       = KIND_NONE;
        end else begin
            phase_cur      = phase_reg;
            depth_cur      = depth_reg;
            wait_comma_cur = wait_comma_reg;
            match_cur      = match_reg;
            kind_cur       = kind_reg;
        end
    end

    bef_name_match u_match (
        .cur       (match_cur),
        .char_code (c),
        .nxt       (match_fed),
        .kind      (match_kind)
    );

    // Value tags by field kind
    always_comb begin
        case (kind_cur)
            KIND_TITLE: begin
                char_tag = TAG_TITLE_CHAR;
                end_tag  = TAG_TITLE_END;
            end
            KIND_AUTHOR: begin
                char_tag = TAG_AUTHOR_CHAR;
                end_tag  = TAG_AUTHOR_END;
            end
            default: begin
                char_tag = TAG_NONE;
                end_tag  = TAG_NONE;
            end
        endcase
    end

    // Phase transitions
    always_comb begin
        phase_next      = phase_cur;
        depth_next      = depth_cur;
        wait_comma_next = wait_comma_cur;
        match_next      = match_cur;
        kind_next       = kind_cur;
        tag             = TAG_NONE;
        case (phase_cur)
            PH_TYPE: begin
                if (c == CH_LBRACE) begin
                    phase_next = PH_KEY;
                end
            end
            PH_KEY: begin
                if (c == CH_COMMA) begin
                    tag        = TAG_KEY_END;
                    phase_next = PH_NAME;
                    match_next = MATCH_CLEAR;
                end else begin
                    tag = TAG_KEY_CHAR;
                end
            end
            PH_NAME: begin
                if (c == CH_EQUAL) begin
                    kind_next       = match_kind;
                    wait_comma_next = 1'b0;
                    phase_next      = PH_WAIT;
                end else begin
                    match_next = match_fed;
                end
            end
            PH_VALUE: begin
                tag = char_tag;
                if (c == CH_LBRACE) begin
                    if (depth_cur != DEPTH_MAX) begin
                        depth_next = depth_cur + DEPTH_ONE;
                    end
                end else if (c == CH_RBRACE) begin
                    if (depth_cur == DEPTH_ONE) begin
                        depth_next      = '0;
                        tag             = end_tag;
                        wait_comma_next = 1'b1;
                        phase_next      = PH_WAIT;
                    end else if (depth_cur != '0) begin
                        depth_next = depth_cur - DEPTH_ONE;
                    end
                end
            end
            PH_WAIT: begin
                if (wait_comma_cur) begin
                    if (c == CH_COMMA) begin
                        phase_next = PH_NAME;
                        match_next = MATCH_CLEAR;
                    end else if (c == CH_RBRACE) begin
                        tag        = TAG_ENTRY_END;
                        phase_next = PH_OUTSIDE;
                    end
                end else if (c == CH_LBRACE) begin
                    phase_next = PH_VALUE;
                    depth_next = DEPTH_ONE;
                end
            end
            default: begin
                phase_next = (c == CH_AT) ? PH_TYPE : PH_OUTSIDE;
            end
        endcase
    end

    assign result.char_out        = c;
    assign result.tag             = tag;
    assign result.depth_saturated = (depth_next == DEPTH_MAX);

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_OUTSIDE;
            depth_reg      <= '0;
            wait_comma_reg <= 1'b0;
            match_reg      <= MATCH_CLEAR;
            kind_reg       <= KIND_NONE;
        end else if (step_en) begin
            phase_reg      <= phase_next;
            depth_reg      <= depth_next;
            wait_comma_reg <= wait_comma_next;
            match_reg      <= match_next;
            kind_reg       <= kind_next;
        end
    end

endmodule

/* hdl/bibtex_entry_field_tagger.sv */
// Top level of the bibliography entry/field tagger: input register, parser, result register.
//
//   channel | direction | payload                                    | handshake
//   s_      | in        | char_code[15:0], start_of_text             | s_valid / s_ready
//   m_      | out       | char_out[15:0], tag[2:0], depth_saturated  | m_valid / m_ready
//
// One character per cycle sustained while m_ready stays high; an accepted
// transaction reaches m_ through the input register, then the result register.
// The parser state advances only when a character moves from the input
// register into the result register, so stalls on m_ready hold everything.
// aresetn is synchronous, active low; it empties both registers and returns
// the parser to outside-entry.
module bibtex_entry_field_tagger (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bef_pkg::bef_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bef_pkg::bef_out_t m_data
);
    import bef_pkg::*;

    logic     in_valid_reg;
    bef_in_t  in_data_reg;
    logic     out_valid_reg;
    bef_out_t out_data_reg;
    logic     advance;
    bef_out_t result;

    // Move a character forward when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    bef_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .in_data (in_data_reg),
        .result  (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

/* hdl/bef_checker.sv */
// Port-level checks for the entry/field tagger, bound to the top level.
module bef_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input bef_pkg::bef_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input bef_pkg::bef_out_t m_data
);
    import bef_pkg::*;

    // No result right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Key end is always the comma, entry end always the closing brace
    a_delims: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.tag != TAG_KEY_END || m_data.char_out == CH_COMMA)
                 && (m_data.tag != TAG_ENTRY_END || m_data.char_out == CH_RBRACE))
        else $error("delimiter tag on wrong character");

    // A value end leaves the depth at zero, so never saturated
    a_end_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.tag == TAG_TITLE_END || m_data.tag == TAG_AUTHOR_END)
        |-> !m_data.depth_saturated && m_data.char_out == CH_RBRACE)
        else $error("value end with bad depth or character");

    // Input side never blocks while the pipeline is empty
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && $past(!s_valid) && $past(aresetn) && $past(!m_valid) |-> s_ready)
        else $error("not ready while empty");

endmodule

bind bibtex_entry_field_tagger bef_checker u_bef_checker (.*);
